@@ hdl/fpga_bitstream_header_parser_core_macros.svh @@
// assertion helpers for the bitstream header parser
// both forms use the clock and reset ports of the asserting module
`ifndef FPGA_BITSTREAM_HEADER_PARSER_CORE_MACROS_SVH
`define FPGA_BITSTREAM_HEADER_PARSER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define FBHP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define FBHP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/fbhp_pkg.sv @@
package fbhp_pkg;

   // field widths
   localparam int LEN_BITS  = 24;
   localparam int BYTE_BITS = 8;
   localparam int WORD_BITS = 32;

   // parse phases
   typedef logic [2:0] phase_type;
   localparam phase_type PH_IDLE     = 3'd0;
   localparam phase_type PH_HDR1     = 3'd1;
   localparam phase_type PH_CSTART   = 3'd2;
   localparam phase_type PH_STRING   = 3'd3;
   localparam phase_type PH_PREAMBLE = 3'd4;
   localparam phase_type PH_CMD      = 3'd5;
   localparam phase_type PH_SKIP     = 3'd6;
   localparam phase_type PH_CAPTURE  = 3'd7;

   // capture targets
   typedef logic [1:0] target_type;
   localparam target_type TGT_NONE = 2'd0;
   localparam target_type TGT_ID   = 2'd1;
   localparam target_type TGT_CTRL = 2'd2;

   typedef logic [2:0] count_type;

   // byte values and opcodes
   localparam logic [7:0] BYTE_DUMMY = 8'hFF;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;
   localparam logic [7:0] OP_NOOP_A  = 8'h79;
   localparam logic [7:0] OP_NOOP_B  = 8'h3B;
   localparam logic [7:0] OP_ID      = 8'hE2;
   localparam logic [7:0] OP_CTRL    = 8'h22;

   // image bounds
   localparam int MIN_IMAGE_LEN = 16;
   localparam int CMD_LOOKAHEAD = 8;
   localparam int PREAMBLE_LEN  = 4;

   // operand bytes before the captured word, and the word's bytes
   localparam count_type OPERAND_SKIP = 3'd3;
   localparam count_type WORD_BYTES   = 3'd4;

   // control word bit that marks an own boot address
   localparam int CTRL_BOOT_BIT = 20;

   // preamble byte at a given offset
   function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hFF;
         2'd1:    b = 8'hFF;
         2'd2:    b = 8'hBD;
         default: b = 8'hB3;
      endcase
      return b;
   endfunction

endpackage

@@ hdl/fpga_bitstream_header_parser_core.sv @@
// Bitstream header parser: takes one image byte per cycle on the req channel (req_first_byte
// marks byte zero and restarts the parse) and delivers one verdict item on the rsp channel once
// the outcome is settled: start and comment header, preamble, then the command walk that captures
// the device ID and control word. Sustained rate is one byte per clock; the byte that settles a
// verdict passes the byte register and the single parse step that sits between it and the
// result register, where the verdict is registered. The input side stalls only while a verdict
// waits in the result register and the byte register is also full. Bytes that come while no
// parse runs, and without req_first_byte, give nothing. csr_image_length is to be written by the
// user only while the block is idle; the block itself does not enforce this. It is always ready.
`include "fpga_bitstream_header_parser_core_macros.svh"

module fpga_bitstream_header_parser_core
   import fbhp_pkg::*;
#(
   parameter int POSITION_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEN_BITS-1:0]  csr_image_length,
   // byte stream
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_BITS-1:0] req_data_byte,
   input  logic                 req_first_byte,
   // verdict
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_bitstream,
   output logic [WORD_BITS-1:0] rsp_device_id,
   output logic                 rsp_has_control_word,
   output logic [WORD_BITS-1:0] rsp_control_word,
   output logic                 rsp_own_boot_address
);

   localparam int PB       = POSITION_BITS;
   localparam int EXT_BITS = (PB > LEN_BITS) ? PB : LEN_BITS;

   // clamped image length
   logic [PB-1:0]       limit_ff;
   logic [PB-1:0]       limit_in;
   logic [EXT_BITS-1:0] len_ext;
   logic [EXT_BITS-1:0] mask_ext;

   // byte register
   logic                 x_valid_ff;
   logic [BYTE_BITS-1:0] x_byte_ff;
   logic                 x_first_ff;
   logic                 advance;

   // parse state
   phase_type      phase_ff,     phase_in;
   logic [PB-1:0]  pos_ff,       pos_in;
   count_type      skip_ff,      skip_in;
   logic [23:0]    shift_ff,     shift_in;
   target_type     tgt_ff,       tgt_in;
   logic [31:0]    id_word_ff,   id_word_in;
   logic           id_seen_ff,   id_seen_in;
   logic [31:0]    ctrl_word_ff, ctrl_word_in;
   logic           ctrl_seen_ff, ctrl_seen_in;
   logic           emit;

   // bound checks
   logic [PB-1:0]  pos_inc;
   logic [PB:0]    pos_inc_ext;
   logic [PB:0]    limit_ext;
   count_type      skip_dec;
   logic           cmd_fail;
   logic           pre_fail;
   logic           str_end;
   logic           short_img;
   logic [31:0]    new_word;

   // result register
   logic           rsp_valid_ff,  rsp_valid_in;
   logic           rsp_isb_ff;
   logic [31:0]    rsp_id_ff;
   logic           rsp_hcw_ff;
   logic [31:0]    rsp_cw_ff;
   logic           rsp_boot_ff;

   // configuration: clamp the length to what the position counter holds
   assign csr_ready = 1'b1;
   assign len_ext   = EXT_BITS'(csr_image_length);
   assign mask_ext  = EXT_BITS'({PB{1'b1}});
   assign limit_in  = (len_ext > mask_ext) ? PB'(mask_ext) : PB'(len_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= limit_in;
      end
   end

   // byte register handshake
   assign advance   = x_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !x_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (req_ready) begin
         x_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_byte_ff  <= req_data_byte;
         x_first_ff <= req_first_byte;
      end
   end

   // look-ahead compares
   assign pos_inc     = pos_ff + PB'(1);
   assign pos_inc_ext = {1'b0, pos_inc};
   assign limit_ext   = {1'b0, limit_ff};
   assign skip_dec    = skip_ff - 3'd1;
   assign cmd_fail    = (pos_inc_ext + (PB+1)'(CMD_LOOKAHEAD)) > limit_ext;
   assign pre_fail    = (pos_inc_ext + (PB+1)'(PREAMBLE_LEN)) > limit_ext;
   assign str_end     = pos_inc >= limit_ff;
   assign short_img   = limit_ext < (PB+1)'(MIN_IMAGE_LEN);
   assign new_word    = {shift_ff, x_byte_ff};

   // one parse step per byte
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      shift_in     = shift_ff;
      tgt_in       = tgt_ff;
      id_word_in   = id_word_ff;
      id_seen_in   = id_seen_ff;
      ctrl_word_in = ctrl_word_ff;
      ctrl_seen_in = ctrl_seen_ff;
      emit         = 1'b0;

      if (x_first_ff) begin
         pos_in       = '0;
         skip_in      = '0;
         shift_in     = '0;
         tgt_in       = TGT_NONE;
         id_word_in   = '0;
         id_seen_in   = 1'b0;
         ctrl_word_in = '0;
         ctrl_seen_in = 1'b0;
         if (short_img || x_byte_ff != BYTE_DUMMY) begin
            emit = 1'b1;
         end else begin
            phase_in = PH_HDR1;
            pos_in   = PB'(1);
         end
      end else begin
         case (phase_ff)
            PH_HDR1: begin
               if (x_byte_ff != BYTE_ZERO) begin
                  emit = 1'b1;
               end else begin
                  phase_in = PH_CSTART;
                  pos_in   = PB'(2);
               end
            end
            PH_CSTART, PH_STRING: begin
               if (phase_ff == PH_CSTART && x_byte_ff == BYTE_DUMMY) begin
                  if (pre_fail) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PH_PREAMBLE;
                     pos_in   = pos_inc;
                     skip_in  = '0;
                  end
               end else begin
                  phase_in = (x_byte_ff == BYTE_ZERO) ? PH_CSTART : PH_STRING;
                  pos_in   = pos_inc;
                  emit     = str_end;
               end
            end
            PH_PREAMBLE: begin
               if (x_byte_ff != preamble_byte(skip_ff[1:0])) begin
                  emit = 1'b1;
               end else if (skip_ff[1:0] == 2'd3) begin
                  skip_in  = '0;
                  pos_in   = pos_inc;
                  phase_in = PH_CMD;
                  emit     = cmd_fail;
               end else begin
                  skip_in = skip_ff + 3'd1;
                  pos_in  = pos_inc;
               end
            end
            PH_CMD: begin
               if (x_byte_ff == BYTE_DUMMY) begin
                  pos_in = pos_inc;
                  emit   = cmd_fail;
               end else if (x_byte_ff == OP_NOOP_A || x_byte_ff == OP_NOOP_B ||
                            x_byte_ff == OP_ID || x_byte_ff == OP_CTRL) begin
                  if (x_byte_ff == OP_ID) begin
                     tgt_in = TGT_ID;
                  end else if (x_byte_ff == OP_CTRL) begin
                     tgt_in = TGT_CTRL;
                  end else begin
                     tgt_in = TGT_NONE;
                  end
                  phase_in = PH_SKIP;
                  skip_in  = OPERAND_SKIP;
                  pos_in   = pos_inc;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_SKIP: begin
               pos_in  = pos_inc;
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  if (tgt_ff == TGT_NONE) begin
                     phase_in = PH_CMD;
                     emit     = cmd_fail;
                  end else begin
                     phase_in = PH_CAPTURE;
                     skip_in  = WORD_BYTES;
                  end
               end
            end
            PH_CAPTURE: begin
               shift_in = new_word[23:0];
               pos_in   = pos_inc;
               skip_in  = skip_dec;
               if (skip_dec == '0) begin
                  if (tgt_ff == TGT_ID) begin
                     id_word_in = new_word;
                     id_seen_in = 1'b1;
                  end else begin
                     ctrl_word_in = new_word;
                     ctrl_seen_in = 1'b1;
                  end
                  tgt_in   = TGT_NONE;
                  phase_in = PH_CMD;
                  emit     = cmd_fail;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // a verdict always returns the parser to idle
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         skip_ff      <= '0;
         shift_ff     <= '0;
         tgt_ff       <= TGT_NONE;
         id_word_ff   <= '0;
         id_seen_ff   <= 1'b0;
         ctrl_word_ff <= '0;
         ctrl_seen_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         shift_ff     <= shift_in;
         tgt_ff       <= tgt_in;
         id_word_ff   <= id_word_in;
         id_seen_ff   <= id_seen_in;
         ctrl_word_ff <= ctrl_word_in;
         ctrl_seen_ff <= ctrl_seen_in;
      end
   end

   // result register
   assign rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_isb_ff  <= id_seen_in;
         rsp_id_ff   <= id_word_in;
         rsp_hcw_ff  <= ctrl_seen_in;
         rsp_cw_ff   <= ctrl_word_in;
         rsp_boot_ff <= ctrl_seen_in && ctrl_word_in[CTRL_BOOT_BIT];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_bitstream     = rsp_isb_ff;
   assign rsp_device_id        = rsp_id_ff;
   assign rsp_has_control_word = rsp_hcw_ff;
   assign rsp_control_word     = rsp_cw_ff;
   assign rsp_own_boot_address = rsp_boot_ff;

   // checks
   `FBHP_ASSERT_NEXT(a_idle_after_verdict, advance && emit, phase_ff == PH_IDLE, "parser not idle after verdict")
   `FBHP_ASSERT_SAME(a_boot_needs_ctrl, rsp_valid_ff && rsp_own_boot_address, rsp_has_control_word, "boot flag without control word")
   `FBHP_ASSERT_SAME(a_ctrl_zero, rsp_valid_ff && !rsp_has_control_word, rsp_control_word == '0, "control word set without capture")
   `FBHP_ASSERT_SAME(a_id_zero, rsp_valid_ff && !rsp_is_bitstream, rsp_device_id == '0, "device id set without capture")
   `FBHP_ASSERT_SAME(a_stall_cause, !req_ready, x_valid_ff && rsp_valid_ff, "input stalled with free slot")

endmodule

@@ tb/testbench.sv @@
module testbench;
   import fbhp_pkg::*;

   localparam int POS_BITS        = 24;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PIPE_PAD        = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PRESSURE_CYCLES = 300;
   localparam int NUM_PHASES      = 8;
   localparam int DIRECTED_ROWS   = 29;
   localparam logic [31:0] SYNC_WORD = 32'hFFFFBDB3;

   typedef struct packed {
      logic                 is_bitstream;
      logic [WORD_BITS-1:0] device_id;
      logic                 has_control_word;
      logic [WORD_BITS-1:0] control_word;
      logic                 own_boot_address;
   } verdict_type;

   typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [BYTE_BITS-1:0] data;
      logic                 first;
      logic [LEN_BITS-1:0]  len;
      logic                 lit;
      verdict_type          want;
   } stim_type;

   localparam verdict_type V_REJECT = '0;
   localparam verdict_type V_ID_ONLY = '{1'b1, 32'h12345678, 1'b0, 32'h0, 1'b0};
   localparam stim_type CLOSE_ITEM = '{ROW_BYTE, BYTE_ZERO, 1'b1, 24'd0, 1'b0, V_REJECT};

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [LEN_BITS-1:0]  csr_image_length;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_BITS-1:0] req_data_byte;
   logic                 req_first_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_is_bitstream;
   logic [WORD_BITS-1:0] rsp_device_id;
   logic                 rsp_has_control_word;
   logic [WORD_BITS-1:0] rsp_control_word;
   logic                 rsp_own_boot_address;

   // predicted parser state
   phase_type           pr_phase;
   logic [POS_BITS-1:0] pr_pos;
   logic [LEN_BITS-1:0] pr_len;
   count_type           pr_left;
   logic [31:0]         pr_shift;
   target_type          pr_target;
   logic [31:0]         pr_id;
   logic                pr_id_seen;
   logic [31:0]         pr_ctrl;
   logic                pr_ctrl_seen;

   verdict_type verdict_q [$];
   stim_type    image_q [$];
   int          mismatches;
   int          stuck;
   int          hold_left;
   logic        hold_req;
   bit          calm_tx;
   bit          calm_rx;

   // directed items: short length, full header with id capture, ignored bytes, restarts
   stim_type script [DIRECTED_ROWS] = '{
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b1, V_REJECT},
      '{ROW_BYTE, 8'h00, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_CFG,  8'h00, 1'b0, 24'd15,      1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b1, V_REJECT},
      '{ROW_CFG,  8'h00, 1'b0, 24'd16,      1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h00, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hBD, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hB3, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hE2, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hA5, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h5A, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hC3, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h12, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h34, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h56, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h78, 1'b0, 24'd0,       1'b1, V_ID_ONLY},
      '{ROW_BYTE, 8'hAA, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h01, 1'b1, 24'd0,       1'b1, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h7E, 1'b0, 24'd0,       1'b1, V_REJECT},
      '{ROW_CFG,  8'h00, 1'b0, 24'hFFFFFF,  1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h00, 1'b0, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'hFF, 1'b1, 24'd0,       1'b0, V_REJECT},
      '{ROW_BYTE, 8'h00, 1'b1, 24'd0,       1'b1, V_REJECT}
   };

   fpga_bitstream_header_parser_core #(
      .POSITION_BITS(POS_BITS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_image_length    (csr_image_length),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_is_bitstream    (rsp_is_bitstream),
      .rsp_device_id       (rsp_device_id),
      .rsp_has_control_word(rsp_has_control_word),
      .rsp_control_word    (rsp_control_word),
      .rsp_own_boot_address(rsp_own_boot_address)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // verdict from the captured words, parser back to idle
   function automatic bit settle_verdict(output verdict_type v);
      pr_phase = PH_IDLE;
      v.is_bitstream     = pr_id_seen;
      v.device_id        = pr_id;
      v.has_control_word = pr_ctrl_seen;
      v.control_word     = pr_ctrl;
      v.own_boot_address = pr_ctrl_seen & pr_ctrl[CTRL_BOOT_BIT];
      return 1'b1;
   endfunction

   // next command position; too few bytes left ends the walk
   function automatic bit enter_command(input logic [POS_BITS-1:0] pos, output verdict_type v);
      v = V_REJECT;
      pr_pos   = pos;
      pr_phase = PH_CMD;
      if (longint'(pos) + CMD_LOOKAHEAD > longint'(pr_len))
         return settle_verdict(v);
      return 1'b0;
   endfunction

   // one accepted byte through the parser, returns 1 when a verdict is due
   function automatic bit parse_step(input logic [7:0] d, input logic first,
                                     output verdict_type v);
      logic [POS_BITS-1:0] nxt;
      v = V_REJECT;
      if (first) begin
         pr_pos       = '0;
         pr_left      = '0;
         pr_shift     = '0;
         pr_target    = TGT_NONE;
         pr_id        = '0;
         pr_id_seen   = 1'b0;
         pr_ctrl      = '0;
         pr_ctrl_seen = 1'b0;
         if (pr_len < MIN_IMAGE_LEN || d != BYTE_DUMMY)
            return settle_verdict(v);
         pr_phase = PH_HDR1;
         pr_pos   = POS_BITS'(1);
         return 1'b0;
      end
      case (pr_phase)
         PH_HDR1: begin
            if (d != BYTE_ZERO)
               return settle_verdict(v);
            pr_phase = PH_CSTART;
            pr_pos   = POS_BITS'(2);
            return 1'b0;
         end
         PH_CSTART, PH_STRING: begin
            nxt = pr_pos + POS_BITS'(1);
            // ff at a string start opens the preamble
            if (pr_phase == PH_CSTART && d == BYTE_DUMMY) begin
               if (longint'(nxt) + PREAMBLE_LEN > longint'(pr_len))
                  return settle_verdict(v);
               pr_phase = PH_PREAMBLE;
               pr_pos   = nxt;
               pr_left  = '0;
               return 1'b0;
            end
            pr_phase = (d == BYTE_ZERO) ? PH_CSTART : PH_STRING;
            pr_pos   = nxt;
            if (longint'(nxt) >= longint'(pr_len))
               return settle_verdict(v);
            return 1'b0;
         end
         PH_PREAMBLE: begin
            if (d != SYNC_WORD[31 - 8 * pr_left[1:0] -: 8])
               return settle_verdict(v);
            if (pr_left[1:0] == 2'd3) begin
               pr_left = '0;
               return enter_command(pr_pos + POS_BITS'(1), v);
            end
            pr_left = pr_left + 3'd1;
            pr_pos  = pr_pos + POS_BITS'(1);
            return 1'b0;
         end
         PH_CMD: begin
            if (d == BYTE_DUMMY)
               return enter_command(pr_pos + POS_BITS'(1), v);
            if (d == OP_NOOP_A || d == OP_NOOP_B)
               pr_target = TGT_NONE;
            else if (d == OP_ID)
               pr_target = TGT_ID;
            else if (d == OP_CTRL)
               pr_target = TGT_CTRL;
            else
               return settle_verdict(v);
            pr_phase = PH_SKIP;
            pr_left  = OPERAND_SKIP;
            pr_pos   = pr_pos + POS_BITS'(1);
            return 1'b0;
         end
         PH_SKIP: begin
            pr_pos  = pr_pos + POS_BITS'(1);
            pr_left = pr_left - 3'd1;
            if (pr_left == '0) begin
               if (pr_target == TGT_NONE)
                  return enter_command(pr_pos, v);
               pr_phase = PH_CAPTURE;
               pr_left  = WORD_BYTES;
               pr_shift = '0;
            end
            return 1'b0;
         end
         PH_CAPTURE: begin
            pr_shift = {pr_shift[23:0], d};
            pr_pos   = pr_pos + POS_BITS'(1);
            pr_left  = pr_left - 3'd1;
            if (pr_left == '0) begin
               if (pr_target == TGT_ID) begin
                  pr_id      = pr_shift;
                  pr_id_seen = 1'b1;
               end else begin
                  pr_ctrl      = pr_shift;
                  pr_ctrl_seen = 1'b1;
               end
               pr_target = TGT_NONE;
               return enter_command(pr_pos, v);
            end
            return 1'b0;
         end
         default: begin
            pr_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_byte(input logic [7:0] d, input logic f);
      image_q.push_back(stim_type'{ROW_BYTE, d, f, 24'd0, 1'b0, V_REJECT});
   endfunction

   // one image: mostly well formed with random content, some noise
   function automatic void build_image();
      int n;
      int str_len;
      int r;
      logic [31:0] w;
      image_q.delete();
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 8);
         add_byte($urandom_range(0, 1) ? BYTE_DUMMY : 8'($urandom_range(0, 255)), 1'b1);
         for (int i = 1; i < n; i++)
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         return;
      end
      add_byte(BYTE_DUMMY, 1'b1);
      add_byte(BYTE_ZERO, 1'b0);
      // comment strings, now and then a long one
      n = $urandom_range(0, 2);
      for (int s = 0; s < n; s++) begin
         str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
         add_byte(8'($urandom_range(1, 254)), 1'b0);
         for (int i = 1; i < str_len; i++)
            add_byte(8'($urandom_range(1, 255)), 1'b0);
         add_byte(BYTE_ZERO, 1'b0);
      end
      add_byte(BYTE_DUMMY, 1'b0);
      // preamble, rarely corrupted
      for (int i = 0; i < PREAMBLE_LEN; i++)
         add_byte(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                : SYNC_WORD[31 - 8 * i -: 8], 1'b0);
      // commands
      n = $urandom_range(0, 5);
      for (int c = 0; c < n; c++) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            add_byte(BYTE_DUMMY, 1'b0);
         end else begin
            add_byte(r == 2 ? OP_NOOP_A : r == 3 ? OP_NOOP_B : r < 7 ? OP_ID : OP_CTRL, 1'b0);
            for (int i = 0; i < OPERAND_SKIP; i++)
               add_byte(8'($urandom_range(0, 255)), 1'b0);
            if (r >= 4) begin
               w = $urandom();
               w[CTRL_BOOT_BIT] = 1'($urandom_range(0, 1));
               for (int i = 0; i < WORD_BYTES; i++)
                  add_byte(w[31 - 8 * i -: 8], 1'b0);
            end
         end
      end
      // unknown opcode ends the walk
      if ($urandom_range(0, 2) == 0) begin
         do
            r = $urandom_range(0, 255);
         while (r == BYTE_DUMMY || r == OP_NOOP_A || r == OP_NOOP_B || r == OP_ID ||
                r == OP_CTRL);
         add_byte(8'(r), 1'b0);
      end
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
         add_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // offer one item and predict its verdict on acceptance
   task automatic offer_byte(input stim_type it);
      int gap;
      bit got;
      verdict_type v;
      gap = calm_tx ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= it.data;
      req_first_byte <= it.first;
      do @(posedge clock); while (!req_ready);
      got = parse_step(it.data, it.first, v);
      if (it.lit)
         verdict_q.push_back(it.want);
      else if (got)
         verdict_q.push_back(v);
   endtask

   // length write once every verdict is in and the pipe has drained
   task automatic write_length(input logic [LEN_BITS-1:0] value);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (PIPE_PAD) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_image_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pr_len = value;
   endtask

   // main stimulus
   initial begin
      logic [LEN_BITS-1:0] len;
      int sent;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_image_length = '0;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_first_byte   = 1'b0;
      hold_req         = 1'b0;
      calm_tx          = 1'b0;
      mismatches       = 0;
      pr_phase         = PH_IDLE;
      pr_pos           = '0;
      pr_len           = '0;
      pr_left          = '0;
      pr_shift         = '0;
      pr_target        = TGT_NONE;
      pr_id            = '0;
      pr_id_seen       = 1'b0;
      pr_ctrl          = '0;
      pr_ctrl_seen     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CFG)
            write_length(script[i].len);
         else
            offer_byte(script[i]);
      end

      // random phases, each under its own image length
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       len = 24'd16;
            1:       len = 24'd17;
            2:       len = 24'($urandom_range(18, 48));
            3:       len = 24'hFFFFFF;
            4:       len = 24'($urandom_range(16, 400));
            5:       len = 24'd0;
            6:       len = 24'd64;
            default: len = 24'($urandom_range(16, 80));
         endcase
         write_length(len);
         if (ph == 2)
            hold_req <= 1'b1;
         sent = 0;
         while (sent < ((len == 0) ? 60 : 190)) begin
            build_image();
            calm_tx = ($urandom_range(0, 4) == 0);
            foreach (image_q[i])
               offer_byte(image_q[i]);
            sent += image_q.size();
         end
         // first byte of zero closes any open parse with a verdict
         offer_byte(CLOSE_ITEM);
      end

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // result side: check each verdict item, random stalls, one long hold-off
   always @(posedge clock) begin : verdict_side
      verdict_type want;
      verdict_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         calm_rx   = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_is_bitstream, rsp_device_id, rsp_has_control_word,
                     rsp_control_word, rsp_own_boot_address};
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict with none expected, is_bitstream %0d device_id %h",
                        $time, seen.is_bitstream, seen.device_id);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (seen.is_bitstream !== want.is_bitstream) begin
                  $display("%0t: is_bitstream expected %0d got %0d",
                           $time, want.is_bitstream, seen.is_bitstream);
                  mismatches++;
               end
               if (seen.device_id !== want.device_id) begin
                  $display("%0t: device_id expected %h got %h",
                           $time, want.device_id, seen.device_id);
                  mismatches++;
               end
               if (seen.has_control_word !== want.has_control_word) begin
                  $display("%0t: has_control_word expected %0d got %0d",
                           $time, want.has_control_word, seen.has_control_word);
                  mismatches++;
               end
               if (seen.control_word !== want.control_word) begin
                  $display("%0t: control_word expected %h got %h",
                           $time, want.control_word, seen.control_word);
                  mismatches++;
               end
               if (seen.own_boot_address !== want.own_boot_address) begin
                  $display("%0t: own_boot_address expected %0d got %0d",
                           $time, want.own_boot_address, seen.own_boot_address);
                  mismatches++;
               end
            end
         end
         if ($urandom_range(0, 149) == 0)
            calm_rx = ~calm_rx;
         if (hold_req) begin
            hold_req <= 1'b0;
            hold_left = PRESSURE_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
            hold_left = calm_rx ? 0 : pick_gap();
         end
      end
   end

   // watchdog on cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
         if (stuck >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

endmodule
